>>> design/wbps_pkg.sv
// Package for the wildcard byte pattern scanner: sizes, register codes,
// and the types shared by the top level and its window cells.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wbps_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int OFFSET_BITS = 32;
   localparam int REG_BYTES = 16;
   localparam int LEN_CAP = (PATTERN_MAX < REG_BYTES) ? PATTERN_MAX : REG_BYTES;
   localparam int LEN_BITS = 5;
   localparam int MASK_BITS = 16;
   localparam int OFFSET_OUT_BITS = 32;
   localparam int WIDE_BITS = (OFFSET_BITS + 1 > OFFSET_OUT_BITS) ?
                              OFFSET_BITS + 1 : OFFSET_OUT_BITS;

   localparam int CSR_INDEX_BITS = 8;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LOW = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_HIGH = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WILDCARD_MASK = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PATTERN_LENGTH = 8'd3;

   // per-beat control to every cell
   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctl_type;

   // compare setup for one cell
   typedef struct packed {
      logic       active;
      logic       wild;
      logic [7:0] pat_byte;
   } cell_cfg_type;

   typedef struct packed {
      logic                       found;
      logic [OFFSET_OUT_BITS-1:0] match_offset;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/wildcard_byte_pattern_scanner_unit.sv
// Results are registered: output register, or skid entry if output stalls.
// Throughput: one byte per cycle; the cell row compares the whole window in
// the cycle a byte is taken, and a two-entry result buffer keeps req_ready up
// while one result waits. req_ready drops only when both entries are full.
// Reset (synchronous) clears the window, byte count, match flag, result
// buffer, pattern and mask, and loads length 1; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module wildcard_byte_pattern_scanner_unit import wbps_pkg::*; (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic [7:0]                 req_data_byte,
   input  wire logic                       req_final_byte,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic                            rsp_found,
   output logic [OFFSET_OUT_BITS-1:0]      rsp_match_offset,
   input  wire logic                       csr_write_enable,
   input  wire logic [CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0]   csr_write_data
);

   // configuration
   logic [63:0]          pattern_low_ff;
   logic [63:0]          pattern_high_ff;
   logic [MASK_BITS-1:0] wildcard_mask_ff;
   logic [LEN_BITS-1:0]  pattern_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_low_ff <= 64'd0;
         pattern_high_ff <= 64'd0;
         wildcard_mask_ff <= '0;
         pattern_length_ff <= LEN_BITS'(1);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_PATTERN_LOW: pattern_low_ff <= csr_write_data[63:0];
            CSR_PATTERN_HIGH: pattern_high_ff <= csr_write_data[63:0];
            CSR_WILDCARD_MASK: wildcard_mask_ff <= csr_write_data[MASK_BITS-1:0];
            CSR_PATTERN_LENGTH: pattern_length_ff <= csr_write_data[LEN_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   logic [LEN_BITS-1:0]    len_eff;
   logic [8*REG_BYTES-1:0] pattern_all;

   always_comb begin
      priority if (pattern_length_ff == '0) begin
         len_eff = LEN_BITS'(1);
      end else if (pattern_length_ff > LEN_BITS'(LEN_CAP)) begin
         len_eff = LEN_BITS'(LEN_CAP);
      end else begin
         len_eff = pattern_length_ff;
      end
   end

   assign pattern_all = {pattern_high_ff, pattern_low_ff};

   // handshake and per-image state
   logic accept;
   logic skid_valid_ff;
   logic out_valid_ff;

   assign req_ready = !skid_valid_ff;
   assign accept = req_valid && req_ready;

   cell_ctl_type ctl;
   assign ctl.load = accept;
   assign ctl.clear = accept && req_final_byte;

   logic [7:0]             win [PATTERN_MAX];
   logic [PATTERN_MAX-1:0] ok_vec;

   for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
      cell_cfg_type cfg;
      logic [7:0]   shift_in;

      if (j == 0) begin : g_head
         assign shift_in = req_data_byte;
      end else begin : g_link
         assign shift_in = win[j-1];
      end

      if (j < LEN_CAP) begin : g_live
         logic [LEN_BITS-1:0] k;
         // cell j holds the byte that lines up with pattern byte len-1-j
         assign k = len_eff - LEN_BITS'(j + 1);
         assign cfg.active = len_eff > LEN_BITS'(j);
         assign cfg.wild = wildcard_mask_ff[k[3:0]];
         assign cfg.pat_byte = pattern_all[{k[3:0], 3'b000} +: 8];
      end else begin : g_idle
         assign cfg.active = 1'b0;
         assign cfg.wild = 1'b0;
         assign cfg.pat_byte = 8'd0;
      end

      wbps_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .cfg      (cfg),
         .shift_in (shift_in),
         .byte_out (win[j]),
         .ok       (ok_vec[j])
      );
   end

   logic [OFFSET_BITS-1:0] bytes_seen_ff;
   logic [OFFSET_BITS-1:0] bytes_seen_in;
   logic                   match_reported_ff;
   logic                   match_reported_in;
   logic [WIDE_BITS-1:0]   count_wide;
   logic [WIDE_BITS-1:0]   offset_wide;
   logic                   not_sat;
   logic                   match_now;
   logic                   miss_now;
   logic                   rsp_make;
   rsp_type                rsp_new;

   assign not_sat = bytes_seen_ff != {OFFSET_BITS{1'b1}};
   assign count_wide = WIDE_BITS'(bytes_seen_ff) + WIDE_BITS'(1);
   assign offset_wide = count_wide - WIDE_BITS'(len_eff);
   assign match_now = !match_reported_ff && not_sat &&
                      (count_wide >= WIDE_BITS'(len_eff)) && (&ok_vec);
   assign miss_now = req_final_byte && !match_reported_ff && !match_now;
   assign rsp_make = accept && (match_now || miss_now);
   assign rsp_new.found = match_now;
   assign rsp_new.match_offset = match_now ? offset_wide[OFFSET_OUT_BITS-1:0] : '0;

   always_comb begin
      bytes_seen_in = bytes_seen_ff;
      match_reported_in = match_reported_ff;
      if (accept) begin
         if (req_final_byte) begin
            bytes_seen_in = '0;
            match_reported_in = 1'b0;
         end else begin
            match_reported_in = match_reported_ff || match_now;
            if (not_sat) begin
               bytes_seen_in = bytes_seen_ff + OFFSET_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         match_reported_ff <= 1'b0;
      end else begin
         bytes_seen_ff <= bytes_seen_in;
         match_reported_ff <= match_reported_in;
      end
   end

   // two-entry result buffer: output register plus skid entry
   rsp_type out_ff;
   rsp_type skid_ff;
   logic    out_stalled;

   assign out_stalled = out_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!out_stalled) begin
            out_valid_ff <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (out_stalled) begin
         skid_valid_ff <= rsp_make;
      end else begin
         out_valid_ff <= rsp_make;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!out_stalled) begin
            out_ff <= skid_ff;
         end
      end else if (out_stalled) begin
         if (rsp_make) begin
            skid_ff <= rsp_new;
         end
      end else if (rsp_make) begin
         out_ff <= rsp_new;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_found = out_ff.found;
   assign rsp_match_offset = out_ff.match_offset;

   // hold the skid entry only behind a waiting output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry valid while output register empty");

   a_miss_offset_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.found) |-> (out_ff.match_offset == '0))
      else $error("not-found result carries a nonzero offset");

   a_match_counted: assert property (@(posedge clock) disable iff (reset)
      match_reported_ff |-> (bytes_seen_ff != '0))
      else $error("match flag set with empty byte count");

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_final_byte) |=> (bytes_seen_ff == '0) && !match_reported_ff)
      else $error("image state not cleared after final beat");

endmodule

`default_nettype wire

>>> design/wbps_cell.sv
// One window cell of the scanner: holds one byte of the sliding window,
// passes it to the next cell each beat and compares the byte it takes in.
// Depends on wbps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wbps_cell import wbps_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cell_ctl_type ctl,
   input  wire cell_cfg_type cfg,
   input  wire logic [7:0]   shift_in,
   output logic [7:0]        byte_out,
   output logic              ok
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // drop the window at the end of an image
   assign byte_in = ctl.clear ? 8'd0 : shift_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= 8'd0;
      end else if (ctl.load) begin
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;
   // compare sees the byte landing here this beat
   assign ok = !cfg.active || cfg.wild || (shift_in == cfg.pat_byte);

endmodule

`default_nettype wire

>>> tb/sv/wildcard_byte_pattern_scanner_unit_tb.sv
// Testbench for wildcard_byte_pattern_scanner_unit. It streams byte images with
// random gaps and back-pressure, and checks each found / not-found report.
// Depends on wbps_pkg and the unit itself.
`timescale 1ns / 1ps

module wildcard_byte_pattern_scanner_unit_tb;
   import wbps_pkg::*;

   localparam int QUIET_LIMIT = 400;
   localparam int DRAIN_CYCLES = 8;
   localparam int ITEM_TARGET = 1550;
   localparam int MAX_IMAGE = 64;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_FIRST =
      CSR_INDEX_BITS'(CSR_PATTERN_LENGTH + 1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNUSED_LAST = '1;

   typedef enum int {IMG_NOISE, IMG_PLANTED, IMG_NEAR_MISS} image_kind_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } byte_beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [7:0]                 req_data_byte = '0;
   logic                       req_final_byte = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic                       rsp_found;
   logic [OFFSET_OUT_BITS-1:0] rsp_match_offset;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0]  csr_index = '0;
   logic [CSR_DATA_BITS-1:0]   csr_write_data = '0;

   // scanner copy: registers
   logic [63:0]          cfg_pat_low = '0;
   logic [63:0]          cfg_pat_high = '0;
   logic [MASK_BITS-1:0] cfg_wild = '0;
   logic [LEN_BITS-1:0]  cfg_len = 5'd1;
   // scanner copy: per-image state
   logic [7:0]             win [PATTERN_MAX];
   logic [OFFSET_BITS-1:0] seen_count;
   bit                     hit_done;

   byte_beat_type byte_feed[$];
   rsp_type       reports_due[$];
   int errors = 0;
   int fed_total = 0;
   int req_gap_max = 0;
   int rsp_stall_max = 0;
   int req_gap_left = 0;
   int rsp_stall_left = 0;

   always #2 clock = ~clock;

   wildcard_byte_pattern_scanner_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_final_byte   (req_final_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_found        (rsp_found),
      .rsp_match_offset (rsp_match_offset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   function automatic int eff_length();
      int n;
      n = int'(cfg_len);
      if (n == 0) n = 1;
      if (n > LEN_CAP) n = LEN_CAP;
      return n;
   endfunction

   function automatic logic [7:0] pat_byte(int k);
      logic [127:0] pat;
      pat = {cfg_pat_high, cfg_pat_low};
      return pat[8*k +: 8];
   endfunction

   function automatic void clear_image();
      foreach (win[i]) win[i] = 8'h00;
      seen_count = '0;
      hit_done = 1'b0;
   endfunction

   // Shift one byte in and queue the report it causes, if any.
   function automatic void scan_byte(logic [7:0] b, logic last);
      logic [OFFSET_BITS:0] upto;
      rsp_type rep;
      int n;
      bit hit;
      n = eff_length();
      for (int i = PATTERN_MAX - 1; i > 0; i--) win[i] = win[i-1];
      win[0] = b;
      upto = {1'b0, seen_count} + (OFFSET_BITS+1)'(1);
      if (!hit_done && seen_count != '1 && upto >= (OFFSET_BITS+1)'(n)) begin
         hit = 1'b1;
         for (int k = 0; k < n; k++)
            if (!cfg_wild[k] && win[n-1-k] != pat_byte(k)) hit = 1'b0;
         if (hit) begin
            hit_done = 1'b1;
            rep.found = 1'b1;
            rep.match_offset = OFFSET_OUT_BITS'(upto - (OFFSET_BITS+1)'(n));
            reports_due.insert(reports_due.size(), rep);
         end
      end
      if (seen_count != '1) seen_count++;
      if (last) begin
         if (!hit_done) begin
            rep.found = 1'b0;
            rep.match_offset = '0;
            reports_due.insert(reports_due.size(), rep);
         end
         clear_image();
      end
   endfunction

   // Request side: hold each beat until taken, then idle for the drawn gap.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_gap_left != 0) begin
            req_valid <= 1'b0;
            req_gap_left <= req_gap_left - 1;
         end else if (byte_feed.size() != 0) begin
            req_valid <= 1'b1;
            req_data_byte <= byte_feed[0].data;
            req_final_byte <= byte_feed[0].last;
            byte_feed.delete(0);
            req_gap_left <= $urandom_range(0, req_gap_max);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response side: check the report first, then predict from the beat taken
   // at this edge, so ordering within the step never matters.
   always @(posedge clock) begin : rsp_side
      rsp_type want;
      int stall;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_stall_left <= 0;
         clear_image();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (reports_due.size() == 0) begin
               $display("%0t: unexpected report: expected none, got found=%0b offset=%0d",
                        $time, rsp_found, rsp_match_offset);
               errors++;
            end else begin
               want = reports_due.pop_front();
               if (rsp_found !== want.found) begin
                  $display("%0t: found mismatch: expected %0b, got %0b",
                           $time, want.found, rsp_found);
                  errors++;
               end
               if (rsp_match_offset !== want.match_offset) begin
                  $display("%0t: match_offset mismatch: expected %0d, got %0d",
                           $time, want.match_offset, rsp_match_offset);
                  errors++;
               end
            end
            stall = $urandom_range(0, rsp_stall_max);
            if (stall != 0) begin
               rsp_ready <= 1'b0;
               rsp_stall_left <= stall - 1;
            end
         end else if (!rsp_ready) begin
            if (rsp_stall_left == 0) rsp_ready <= 1'b1;
            else rsp_stall_left <= rsp_stall_left - 1;
         end
         if (req_valid && req_ready) scan_byte(req_data_byte, req_final_byte);
      end
   end

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_PATTERN_LOW:    cfg_pat_low = value;
         CSR_PATTERN_HIGH:   cfg_pat_high = value;
         CSR_WILDCARD_MASK:  cfg_wild = value[MASK_BITS-1:0];
         CSR_PATTERN_LENGTH: cfg_len = value[LEN_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic feed(logic [7:0] d, logic last);
      byte_beat_type nb;
      nb.data = d;
      nb.last = last;
      byte_feed.insert(byte_feed.size(), nb);
      fed_total++;
   endtask

   // Wait until every beat is taken and every report is in, then let the unit
   // idle so it is quiet before the next setting.
   task automatic settle();
      do @(negedge clock);
      while (byte_feed.size() != 0 || req_valid || reports_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic queue_image(int n, image_kind_type kind);
      logic [7:0] img [MAX_IMAGE];
      int plen;
      int at;
      int k;
      bit alpha;
      plen = eff_length();
      alpha = 1'($urandom_range(0, 1));
      // bias toward pattern bytes so partial matches show up often
      for (int i = 0; i < n; i++)
         img[i] = (alpha && $urandom_range(0, 3) != 0) ?
                  pat_byte($urandom_range(0, plen - 1)) : 8'($urandom);
      if (kind != IMG_NOISE && n >= plen) begin
         at = $urandom_range(0, n - plen);
         for (int i = 0; i < plen; i++)
            if (!cfg_wild[i]) img[at+i] = pat_byte(i);
         if (kind == IMG_NEAR_MISS) begin
            k = $urandom_range(0, plen - 1);
            img[at+k] = ~pat_byte(k);
         end
      end
      for (int i = 0; i < n; i++) feed(img[i], i == n - 1);
   endtask

   task automatic pick_setting();
      logic [63:0] lo;
      logic [63:0] hi;
      logic [63:0] mask;
      logic [63:0] len;
      case ($urandom_range(0, 5))
         0: lo = '0;
         1: lo = '1;
         default: lo = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 5))
         0: hi = '0;
         1: hi = '1;
         default: hi = {$urandom, $urandom};
      endcase
      case ($urandom_range(0, 4))
         0: mask = '0;
         1: mask = 64'hFFFF;
         2: mask = 64'($urandom);
         default: mask = 64'($urandom & $urandom & $urandom);
      endcase
      case ($urandom_range(0, 7))
         0: len = 64'd0;
         1: len = 64'd1;
         2: len = 64'd16;
         3: len = 64'($urandom_range(17, 31));
         default: len = 64'($urandom_range(1, 16));
      endcase
      write_reg(CSR_PATTERN_LOW, lo);
      write_reg(CSR_PATTERN_HIGH, hi);
      write_reg(CSR_WILDCARD_MASK, mask);
      write_reg(CSR_PATTERN_LENGTH, len);
      if ($urandom_range(0, 5) == 0)
         write_reg(CSR_INDEX_BITS'($urandom_range(CSR_UNUSED_FIRST, CSR_UNUSED_LAST)),
                   {$urandom, $urandom});
   endtask

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_enable || reset)
            quiet = 0;
         else
            quiet++;
      end
      $display("wildcard_byte_pattern_scanner_unit_tb: errors");
      $finish;
   end

   initial begin : stimulus
      int n;
      image_kind_type kind;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset pattern: one byte, 0x00, no wildcard
      feed(8'hFF, 1'b0);
      feed(8'h00, 1'b1);
      feed(8'hAB, 1'b1);
      feed(8'h00, 1'b1);
      settle();

      write_reg(CSR_PATTERN_LOW, 64'h0000_0000_4433_2211);
      write_reg(CSR_PATTERN_HIGH, 64'hFFEE_DDCC_BBAA_9988);
      write_reg(CSR_WILDCARD_MASK, 64'h0002);
      write_reg(CSR_PATTERN_LENGTH, 64'd4);
      write_reg(CSR_UNUSED_FIRST, '1);
      write_reg(CSR_UNUSED_LAST, '1);
      // image shorter than the pattern
      feed(8'h11, 1'b0);
      feed(8'h99, 1'b0);
      feed(8'h33, 1'b1);
      // match that ends on the final byte, wildcard slot holding 0x00
      feed(8'h55, 1'b0);
      feed(8'h11, 1'b0);
      feed(8'h00, 1'b0);
      feed(8'h33, 1'b0);
      feed(8'h44, 1'b1);
      // second match in one image stays silent, and so does its final byte
      feed(8'h11, 1'b0);
      feed(8'hFF, 1'b0);
      feed(8'h33, 1'b0);
      feed(8'h44, 1'b0);
      feed(8'h11, 1'b0);
      feed(8'h22, 1'b0);
      feed(8'h33, 1'b0);
      feed(8'h44, 1'b0);
      feed(8'h00, 1'b1);
      settle();

      // zero length behaves as one
      write_reg(CSR_PATTERN_LENGTH, 64'd0);
      feed(8'h22, 1'b0);
      feed(8'h11, 1'b1);
      settle();

      while (fed_total < ITEM_TARGET) begin
         req_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
         rsp_stall_max = ($urandom_range(0, 2) == 0) ? 0 : 5;
         pick_setting();
         @(negedge clock);
         repeat ($urandom_range(4, 10)) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, MAX_IMAGE) :
                $urandom_range(1, 24);
            case ($urandom_range(0, 3))
               0: kind = IMG_NOISE;
               3: kind = IMG_NEAR_MISS;
               default: kind = IMG_PLANTED;
            endcase
            queue_image(n, kind);
         end
         settle();
      end

      if (errors == 0 && reports_due.size() == 0)
         $display("wildcard_byte_pattern_scanner_unit_tb: clean");
      else
         $display("wildcard_byte_pattern_scanner_unit_tb: errors");
      $finish;
   end

endmodule

>>> wildcard_byte_pattern_scanner_unit.f
design/wbps_pkg.sv
design/wbps_cell.sv
design/wildcard_byte_pattern_scanner_unit.sv
tb/sv/wildcard_byte_pattern_scanner_unit_tb.sv
